FILE: rtl/v2a_pkg.sv
// ----------------------------------------------------------------------------
// v2a_pkg
// Shared types, codes and helpers for the 2d vector arithmetic unit.
// ----------------------------------------------------------------------------
package v2a_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_SUB   = 3'd1;
  localparam logic [2:0] FUNC_SCALE = 3'd2;
  localparam logic [2:0] FUNC_DOT   = 3'd3;
  localparam logic [2:0] FUNC_MAG   = 3'd4;
  localparam logic [2:0] FUNC_NORM  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic signed [64:0] S32_MAX65 = 65'sh0_7FFF_FFFF;
  localparam logic signed [64:0] S32_MIN65 = -65'sh0_8000_0000;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clamp_t;

  // control carried alongside the square root and divider
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [1:0]         status;
    logic [31:0]        ax_abs;
    logic [31:0]        ay_abs;
    logic               ax_neg;
    logic               ay_neg;
  } ctl_t;

  function automatic logic signed [64:0] sx65(input logic [31:0] v);
    sx65 = $signed({{33{v[31]}}, v});
  endfunction

  function automatic clamp_t sat32(input logic signed [64:0] v);
    clamp_t c;
    if (v > S32_MAX65) begin
      c.sat = 1'b1;
      c.val = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN65) begin
      c.sat = 1'b1;
      c.val = 32'sh8000_0000;
    end else begin
      c.sat = 1'b0;
      c.val = v[31:0];
    end
    sat32 = c;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? 32'(-v) : v;
  endfunction

endpackage

FILE: rtl/v2a_if.sv
// ----------------------------------------------------------------------------
// v2a_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface v2a_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] scale;

  modport source (output valid, func, a_x, a_y, b_x, b_y, scale, input ready);
  modport sink   (input valid, func, a_x, a_y, b_x, b_y, scale, output ready);
endinterface

interface v2a_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic [1:0]         status;

  modport source (output valid, result_x, result_y, status, input ready);
  modport sink   (input valid, result_x, result_y, status, output ready);
endinterface

FILE: rtl/v2a_mul.sv
// ----------------------------------------------------------------------------
// v2a_mul
// Registered signed 32 x 32 multiplier lane.
// ----------------------------------------------------------------------------
module v2a_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

FILE: rtl/v2a_sqrt.sv
// ----------------------------------------------------------------------------
// v2a_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module v2a_sqrt import v2a_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] s,
  input  ctl_t        in_ctl,
  output logic        out_valid,
  output logic [31:0] root,
  output ctl_t        out_ctl
);

  localparam int NS = 32;

  logic [63:0] s_s    [NS+1];
  logic [32:0] rem_s  [NS+1];
  logic [31:0] root_s [NS+1];
  ctl_t        ctl_s  [NS+1];
  logic        v_s    [NS+1];

  assign s_s[0]    = s;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign ctl_s[0]  = in_ctl;
  assign v_s[0]    = in_valid;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;

    assign rem_sh = {rem_s[k], s_s[k][63:62]};
    assign trial  = {1'b0, root_s[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_s[k+1]    <= {s_s[k][61:0], 2'b00};
        rem_s[k+1]  <= ge ? 33'(rem_sh - trial) : 33'(rem_sh);
        root_s[k+1] <= {root_s[k][30:0], ge};
        ctl_s[k+1]  <= ctl_s[k];
      end
    end
  end

  assign out_valid = v_s[NS];
  assign root      = root_s[NS];
  assign out_ctl   = ctl_s[NS];

endmodule

FILE: rtl/v2a_div.sv
// ----------------------------------------------------------------------------
// v2a_div
// Pipelined restoring divider, (n << FRAC_BITS) / m for two lanes.
// ----------------------------------------------------------------------------
module v2a_div import v2a_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          m,
  input  logic [31:0]          nx,
  input  logic [31:0]          ny,
  input  ctl_t                 in_ctl,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   qx,
  output logic [FRAC_BITS:0]   qy,
  output ctl_t                 out_ctl
);

  // quotient never exceeds 2^FRAC_BITS since m >= each component
  localparam int DW = 32 + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;
  localparam int NS = FRAC_BITS + 1;

  logic [DW-1:0] rx_s [NS+1];
  logic [DW-1:0] ry_s [NS+1];
  logic [QW-1:0] qx_s [NS+1];
  logic [QW-1:0] qy_s [NS+1];
  logic [31:0]   m_s  [NS+1];
  ctl_t          ctl_s[NS+1];
  logic          v_s  [NS+1];

  assign rx_s[0]  = {nx, {FRAC_BITS{1'b0}}};
  assign ry_s[0]  = {ny, {FRAC_BITS{1'b0}}};
  assign qx_s[0]  = '0;
  assign qy_s[0]  = '0;
  assign m_s[0]   = m;
  assign ctl_s[0] = in_ctl;
  assign v_s[0]   = in_valid;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] dv;
    logic          ge_x;
    logic          ge_y;

    assign dv   = DW'(m_s[k]) << (FRAC_BITS - k);
    assign ge_x = rx_s[k] >= dv;
    assign ge_y = ry_s[k] >= dv;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_s[k+1]  <= ge_x ? rx_s[k] - dv : rx_s[k];
        ry_s[k+1]  <= ge_y ? ry_s[k] - dv : ry_s[k];
        qx_s[k+1]  <= {qx_s[k][QW-2:0], ge_x};
        qy_s[k+1]  <= {qy_s[k][QW-2:0], ge_y};
        m_s[k+1]   <= m_s[k];
        ctl_s[k+1] <= ctl_s[k];
      end
    end
  end

  assign out_valid = v_s[NS];
  assign qx        = qx_s[NS];
  assign qy        = qy_s[NS];
  assign out_ctl   = ctl_s[NS];

endmodule

FILE: rtl/vector2_arith_unit_top.sv
// ----------------------------------------------------------------------------
// vector2_arith_unit_top
// 2d vector alu in signed fixed point: add, sub, scale, dot, magnitude, normalize.
// ----------------------------------------------------------------------------
// One item is accepted in every cycle in which the pipeline is not held. The
// path is fully pipelined: input register, multiplier stage, combine stage, a
// 32-stage square root, a magnitude check stage, a FRAC_BITS + 1 stage
// divider and the output register. All operations use the same path so results
// leave in order. When the result is not taken the whole pipeline holds.
module vector2_arith_unit_top import v2a_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  v2a_req_if.sink   req,
  v2a_rsp_if.source rsp
);

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // input stage
  logic               v1;
  logic [2:0]         func1;
  logic signed [31:0] ax1, ay1, bx1, by1, sc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1 <= req.func;
      ax1   <= req.a_x;
      ay1   <= req.a_y;
      bx1   <= req.b_x;
      by1   <= req.b_y;
      sc1   <= req.scale;
    end
  end

  // multiplier stage
  logic signed [31:0] op0, op1;
  logic signed [63:0] p0, p1;

  always_comb begin
    case (func1)
      FUNC_SCALE: begin
        op0 = sc1;
        op1 = sc1;
      end
      FUNC_DOT: begin
        op0 = bx1;
        op1 = by1;
      end
      default: begin
        op0 = ax1;
        op1 = ay1;
      end
    endcase
  end

  v2a_mul u_mul_x (.clk(clk), .en(en), .a(ax1), .b(op0), .p(p0));
  v2a_mul u_mul_y (.clk(clk), .en(en), .a(ay1), .b(op1), .p(p1));

  logic       v2;
  logic [2:0] func2;
  clamp_t     asx2, asy2;
  logic [31:0] ax2, ay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func2 <= func1;
      ax2   <= ax1;
      ay2   <= ay1;
      if (func1 == FUNC_SUB) begin
        asx2 <= sat32(sx65(ax1) - sx65(bx1));
        asy2 <= sat32(sx65(ay1) - sx65(by1));
      end else begin
        asx2 <= sat32(sx65(ax1) + sx65(bx1));
        asy2 <= sat32(sx65(ay1) + sx65(by1));
      end
    end
  end

  // combine stage
  logic signed [64:0] px65, py65, dot65;
  clamp_t             scx, scy, dotc;
  ctl_t               ctl_c;
  logic [63:0]        sq_sum;

  assign px65   = $signed({p0[63], p0});
  assign py65   = $signed({p1[63], p1});
  assign dot65  = px65 + py65;
  assign scx    = sat32(px65 >>> FRAC_BITS);
  assign scy    = sat32(py65 >>> FRAC_BITS);
  assign dotc   = sat32(dot65 >>> FRAC_BITS);
  assign sq_sum = 64'(p0) + 64'(p1);

  always_comb begin
    ctl_c.func   = func2;
    ctl_c.ax_abs = abs32(ax2);
    ctl_c.ay_abs = abs32(ay2);
    ctl_c.ax_neg = ax2[31];
    ctl_c.ay_neg = ay2[31];
    ctl_c.rx     = '0;
    ctl_c.ry     = '0;
    ctl_c.status = ST_OK;
    case (func2)
      FUNC_ADD, FUNC_SUB: begin
        ctl_c.rx     = asx2.val;
        ctl_c.ry     = asy2.val;
        ctl_c.status = (asx2.sat || asy2.sat) ? ST_SAT : ST_OK;
      end
      FUNC_SCALE: begin
        ctl_c.rx     = scx.val;
        ctl_c.ry     = scy.val;
        ctl_c.status = (scx.sat || scy.sat) ? ST_SAT : ST_OK;
      end
      FUNC_DOT: begin
        ctl_c.rx     = dotc.val;
        ctl_c.status = dotc.sat ? ST_SAT : ST_OK;
      end
      default: begin
      end
    endcase
  end

  logic        v3;
  logic [63:0] s3;
  ctl_t        ctl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3   <= sq_sum;
      ctl3 <= ctl_c;
    end
  end

  // square root
  logic        vq;
  logic [31:0] root;
  ctl_t        ctl_q;

  v2a_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .s(s3), .in_ctl(ctl3),
    .out_valid(vq), .root(root), .out_ctl(ctl_q)
  );

  // magnitude check stage
  ctl_t        ctl_m;
  logic        vm;
  logic [31:0] mm;
  ctl_t        ctl4;

  always_comb begin
    ctl_m = ctl_q;
    case (ctl_q.func)
      FUNC_MAG: begin
        ctl_m.rx     = root[31] ? 32'sh7FFF_FFFF : $signed(root);
        ctl_m.ry     = '0;
        ctl_m.status = root[31] ? ST_SAT : ST_OK;
      end
      FUNC_NORM: begin
        ctl_m.rx     = '0;
        ctl_m.ry     = '0;
        ctl_m.status = (root == '0) ? ST_ZERO : ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm   <= root;
      ctl4 <= ctl_m;
    end
  end

  // divider
  logic               vd;
  logic [FRAC_BITS:0] qx, qy;
  ctl_t               ctl_d;

  v2a_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vm), .m(mm),
    .nx(ctl4.ax_abs), .ny(ctl4.ay_abs), .in_ctl(ctl4),
    .out_valid(vd), .qx(qx), .qy(qy), .out_ctl(ctl_d)
  );

  // output register
  logic signed [31:0] qx32, qy32;
  assign qx32 = $signed(32'(qx));
  assign qy32 = $signed(32'(qy));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.status <= ctl_d.status;
      if (ctl_d.func == FUNC_NORM && ctl_d.status == ST_OK) begin
        rsp.result_x <= ctl_d.ax_neg ? -qx32 : qx32;
        rsp.result_y <= ctl_d.ay_neg ? -qy32 : qy32;
      end else begin
        rsp.result_x <= ctl_d.rx;
        rsp.result_y <= ctl_d.ry;
      end
    end
  end

`ifndef SYNTHESIS
  a_zero_vec_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_ZERO |-> rsp.result_x == '0 && rsp.result_y == '0)
    else $error("zero-vector normalize gave nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.status != 2'd3)
    else $error("undefined status code");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    vm && ctl4.func == FUNC_NORM && ctl4.status == ST_OK |-> mm != '0)
    else $error("divider fed a zero magnitude");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result valid after reset");
`endif

endmodule
